// File: rtl/core/cec_frame_receiver_assert.svh
// Assertion macros for the CEC frame receiver core.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef CEC_FRAME_RECEIVER_ASSERT_SVH
`define CEC_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CEC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cec_frame_receiver: same-cycle check failed");
`define CEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cec_frame_receiver: next-cycle check failed");
`else
`define CEC_ASSERT_IMPLY(lbl, ante, cons)
`define CEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/cec_fr_pkg.sv
// Shared types, constants and helpers for the CEC frame receiver.
// No dependencies.
package cec_fr_pkg;

  localparam int BUF_BYTES = 16;
  localparam int POS_W     = 6;
  localparam int IDX_W     = $clog2(BUF_BYTES);
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0] BUF_BYTES_POS = POS_W'(BUF_BYTES);
  localparam logic [POS_W-1:0] POS_MAX       = '1;
  localparam logic [3:0]       ADDR_BCAST    = 4'hf;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_BIT     = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_ABORT   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR  = 1'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic       bit_value;
    logic [4:0] read_index;
    logic [7:0] error_code;
  } in_item_t;

  typedef struct packed {
    logic nacked;
    logic overrun;
    logic ignore;
    logic eom;
    logic dataeom;
    logic doack;
    logic bcast;
    logic active;
  } flags_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       drive_ack;
    logic       ack_value;
    logic       ack_phase;
    logic       frame_done;
    logic [7:0] status_word;
    logic       message_pending;
    logic       nack_frame_request;
    logic       abort_reported;
    logic [7:0] reported_error;
    logic       receiving;
  } result_t;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    next_pos = (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

endpackage

// File: rtl/core/cec_fr_in_stage.sv
// Input register for the CEC frame receiver: holds one accepted item.
// Depends on cec_fr_pkg.
module cec_fr_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cec_fr_pkg::in_item_t in_item,
  output logic                 item_valid,
  output cec_fr_pkg::in_item_t item,
  input  logic                 item_take
);

  logic                 valid_r;
  logic                 valid_nxt;
  cec_fr_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/core/cec_fr_engine.sv
// Frame state, message store, config registers and result register.
// Depends on cec_fr_pkg and cec_frame_receiver_assert.svh.
`include "cec_frame_receiver_assert.svh"

module cec_fr_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  cec_fr_pkg::in_item_t             item,
  output logic                             item_take,
  input  logic                             cfg_we,
  input  logic [cec_fr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                      cfg_wdata,
  output logic                             res_valid,
  output cec_fr_pkg::result_t              res,
  input  logic                             res_ready
);

  logic                           proc;
  cec_fr_pkg::flags_t             flg_r;
  cec_fr_pkg::flags_t             flg_nxt;
  logic [cec_fr_pkg::POS_W-1:0]   pos_r;
  logic [cec_fr_pkg::POS_W-1:0]   pos_nxt;
  logic [7:0]                     shift_r;
  logic [7:0]                     shift_nxt;
  logic [7:0]                     status_r;
  logic [7:0]                     status_nxt;
  logic [15:0]                    own_mask_r;
  logic                           monitor_r;
  logic [7:0]                     data_r [cec_fr_pkg::BUF_BYTES];
  logic                           wr_en;
  logic [7:0]                     sb;
  logic                           nack;
  logic                           ackv;
  logic [cec_fr_pkg::POS_W-1:0]   rd_ext;
  logic [cec_fr_pkg::POS_W-1:0]   rd_off;
  logic [7:0]                     rd_data;
  logic                           res_valid_r;
  logic                           res_valid_nxt;
  cec_fr_pkg::result_t            res_r;
  cec_fr_pkg::result_t            res_nxt;

  assign item_take = !res_valid_r || res_ready;
  assign proc      = item_valid && item_take;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign rd_ext = cec_fr_pkg::POS_W'(item.read_index);
  assign rd_off = rd_ext - cec_fr_pkg::POS_W'(1);

  always_comb begin
    if (rd_ext == '0) begin
      rd_data = status_r;
    end else if (rd_ext > cec_fr_pkg::BUF_BYTES_POS) begin
      rd_data = 8'd0;
    end else begin
      rd_data = data_r[rd_off[cec_fr_pkg::IDX_W-1:0]];
    end
  end

  always_comb begin
    flg_nxt    = flg_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    sb         = {shift_r[6:0], item.bit_value};
    nack       = 1'b0;
    ackv       = flg_r.bcast ? item.bit_value : ~item.bit_value;
    res_nxt    = '0;
    case (item.kind)
      cec_fr_pkg::KIND_START: begin
        pos_nxt         = '0;
        shift_nxt       = 8'd1;
        flg_nxt         = '0;
        flg_nxt.active  = 1'b1;
        flg_nxt.dataeom = 1'b1;
      end
      cec_fr_pkg::KIND_BIT: begin
        if (flg_r.active) begin
          if (flg_r.dataeom) begin
            if (shift_r != 8'd0) begin
              if (shift_r[7]) begin
                if (pos_r == '0) begin
                  if (sb[3:0] == cec_fr_pkg::ADDR_BCAST) begin
                    flg_nxt.bcast = 1'b1;
                  end else if (own_mask_r[sb[3:0]]) begin
                    flg_nxt.doack = 1'b1;
                  end
                  if (status_r != 8'd0) begin
                    nack           = 1'b1;
                    flg_nxt.ignore = 1'b1;
                  end
                end else if (pos_r == cec_fr_pkg::BUF_BYTES_POS) begin
                  flg_nxt.overrun = 1'b1;
                  nack            = 1'b1;
                end
                if (nack) begin
                  flg_nxt.doack = flg_nxt.bcast;
                end else if (!flg_nxt.ignore && !flg_nxt.overrun &&
                             pos_r < cec_fr_pkg::BUF_BYTES_POS) begin
                  wr_en = 1'b1;
                end
                pos_nxt   = cec_fr_pkg::next_pos(pos_r);
                shift_nxt = 8'd0;
              end else begin
                shift_nxt = sb;
              end
            end else begin
              if (item.bit_value) begin
                flg_nxt.eom = 1'b1;
              end
              flg_nxt.dataeom = 1'b0;
            end
          end else begin
            res_nxt.ack_value = ackv;
            res_nxt.ack_phase = 1'b1;
            if (!ackv) begin
              flg_nxt.nacked = 1'b1;
            end
            if (!ackv || flg_r.eom) begin
              if (!flg_r.ignore) begin
                status_nxt = {flg_nxt.nacked, flg_r.overrun, pos_r};
              end
              flg_nxt            = '0;
              res_nxt.frame_done = 1'b1;
            end else begin
              shift_nxt       = 8'd1;
              flg_nxt.dataeom = 1'b1;
            end
          end
        end
      end
      cec_fr_pkg::KIND_RELEASE: begin
        status_nxt = 8'd0;
      end
      cec_fr_pkg::KIND_READ: begin
        res_nxt.read_data = rd_data;
      end
      cec_fr_pkg::KIND_ABORT: begin
        if (flg_r != '0) begin
          res_nxt.nack_frame_request = flg_r.bcast;
          res_nxt.abort_reported     = 1'b1;
          res_nxt.reported_error     = item.error_code;
          flg_nxt                    = '0;
        end
      end
      default: begin
      end
    endcase
    res_nxt.drive_ack       = flg_nxt.doack && !monitor_r;
    res_nxt.status_word     = status_nxt;
    res_nxt.message_pending = (status_nxt != 8'd0);
    res_nxt.receiving       = flg_nxt.active;
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (proc) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r       <= '0;
      pos_r       <= '0;
      shift_r     <= 8'd0;
      status_r    <= 8'd0;
      own_mask_r  <= 16'd0;
      monitor_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (proc) begin
        flg_r    <= flg_nxt;
        pos_r    <= pos_nxt;
        shift_r  <= shift_nxt;
        status_r <= status_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          cec_fr_pkg::CFG_OWN_MASK: own_mask_r <= cfg_wdata;
          cec_fr_pkg::CFG_MONITOR:  monitor_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
    if (proc && wr_en) begin
      data_r[pos_r[cec_fr_pkg::IDX_W-1:0]] <= sb;
    end
  end

  `CEC_ASSERT_IMPLY(a_idle_flags_clear, !flg_r.active, flg_r == '0)
  `CEC_ASSERT_NEXT(a_start_activates, proc && item.kind == cec_fr_pkg::KIND_START, flg_r.active)
  `CEC_ASSERT_IMPLY(a_done_on_ack_slot, res_valid_r && res_r.frame_done, res_r.ack_phase)
  `CEC_ASSERT_IMPLY(a_abort_ends_rx, res_valid_r && res_r.abort_reported, !res_r.receiving)

endmodule

// File: rtl/core/cec_frame_receiver.sv
// Top level of the CEC frame receiver core.
// Depends on cec_fr_pkg, cec_fr_in_stage and cec_fr_engine.
//
// Takes one decoded CEC event (start, bit, release, read, abort) per item and returns
// one result item per event, carrying ack decisions, frame completion, the pending
// status word and read data. Throughput is one item per clock while out_ready is high;
// each event passes through the input register and the result register around
// the single-pass frame logic. Configuration writes are taken every cycle (cfg_ready
// is always high) and should be issued only while the core is idle.
module cec_frame_receiver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_kind,
  input  logic                             in_bit_value,
  input  logic [4:0]                       in_read_index,
  input  logic [7:0]                       in_error_code,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cec_fr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_read_data,
  output logic                             out_drive_ack,
  output logic                             out_ack_value,
  output logic                             out_ack_phase,
  output logic                             out_frame_done,
  output logic [7:0]                       out_status_word,
  output logic                             out_message_pending,
  output logic                             out_nack_frame_request,
  output logic                             out_abort_reported,
  output logic [7:0]                       out_reported_error,
  output logic                             out_receiving
);

  cec_fr_pkg::in_item_t in_item;
  cec_fr_pkg::in_item_t item;
  cec_fr_pkg::result_t  res;
  logic                 item_valid;
  logic                 item_take;

  assign in_item.kind       = in_kind;
  assign in_item.bit_value  = in_bit_value;
  assign in_item.read_index = in_read_index;
  assign in_item.error_code = in_error_code;

  assign cfg_ready = 1'b1;

  cec_fr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  cec_fr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .res_valid  (out_valid),
    .res        (res),
    .res_ready  (out_ready)
  );

  assign out_read_data          = res.read_data;
  assign out_drive_ack          = res.drive_ack;
  assign out_ack_value          = res.ack_value;
  assign out_ack_phase          = res.ack_phase;
  assign out_frame_done         = res.frame_done;
  assign out_status_word        = res.status_word;
  assign out_message_pending    = res.message_pending;
  assign out_nack_frame_request = res.nack_frame_request;
  assign out_abort_reported     = res.abort_reported;
  assign out_reported_error     = res.reported_error;
  assign out_receiving          = res.receiving;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for cec_frame_receiver: CEC bit events in, one result item per event.
// Predicts each result from its own model of the frame logic; depends only on cec_fr_pkg
// and the RTL.
`timescale 1ns / 1ps

module testbench;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_kind = '0;
  logic       in_bit_value = 1'b0;
  logic [4:0] in_read_index = '0;
  logic [7:0] in_error_code = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [cec_fr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_drive_ack;
  logic       out_ack_value;
  logic       out_ack_phase;
  logic       out_frame_done;
  logic [7:0] out_status_word;
  logic       out_message_pending;
  logic       out_nack_frame_request;
  logic       out_abort_reported;
  logic [7:0] out_reported_error;
  logic       out_receiving;

  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  cec_frame_receiver u_dut (.*);

  logic [7:0]  msg_store [0:cec_fr_pkg::BUF_BYTES];
  bit          written [0:31];
  logic [7:0]  shift_reg;
  logic [5:0]  byte_pos;
  cec_fr_pkg::flags_t rx_flags;
  logic [15:0] own_mask;
  logic        monitor;

  cec_fr_pkg::result_t receiver_outcomes [$];
  cec_fr_pkg::result_t next_outcome;
  int      mismatches = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      frames_finished = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results outstanding", receiver_outcomes.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cec_fr_pkg::result_t advance_receiver(cec_fr_pkg::in_item_t it);
    cec_fr_pkg::result_t r;
    cec_fr_pkg::flags_t  f;
    logic       b;
    logic       nack;
    logic [3:0] addr;
    logic [7:0] sb;
    r = '0;
    case (it.kind)
      cec_fr_pkg::KIND_START: begin
        byte_pos = '0;
        shift_reg = 8'd1;
        rx_flags = '0;
        rx_flags.active = 1'b1;
        rx_flags.dataeom = 1'b1;
      end
      cec_fr_pkg::KIND_BIT: begin
        if (rx_flags.active) begin
          f = rx_flags;
          b = it.bit_value;
          if (f.dataeom) begin
            if (shift_reg != 8'd0) begin
              sb = {shift_reg[6:0], b};
              if (shift_reg[7]) begin
                nack = 1'b0;
                if (byte_pos == 0) begin
                  addr = sb[3:0];
                  if (addr == cec_fr_pkg::ADDR_BCAST) f.bcast = 1'b1;
                  else if (own_mask[addr]) f.doack = 1'b1;
                  if (msg_store[0] != 8'd0) begin
                    nack = 1'b1;
                    f.ignore = 1'b1;
                  end
                end else if (byte_pos == cec_fr_pkg::BUF_BYTES) begin
                  f.overrun = 1'b1;
                  nack = 1'b1;
                end
                if (nack) begin
                  f.doack = f.bcast;
                end else if (!f.ignore && !f.overrun && byte_pos < cec_fr_pkg::BUF_BYTES) begin
                  msg_store[int'(byte_pos) + 1] = sb;
                  written[int'(byte_pos) + 1] = 1'b1;
                end
                byte_pos = (byte_pos == 6'd63) ? byte_pos : byte_pos + 6'd1;
                sb = '0;
              end
              shift_reg = sb;
            end else begin
              if (b) f.eom = 1'b1;
              f.dataeom = 1'b0;
            end
          end else begin
            if (!f.bcast) b = ~b;
            r.ack_phase = 1'b1;
            r.ack_value = b;
            if (!b) f.nacked = 1'b1;
            if (!b || f.eom) begin
              if (!f.ignore) msg_store[0] = {f.nacked, f.overrun, byte_pos};
              f = '0;
              r.frame_done = 1'b1;
            end else begin
              shift_reg = 8'd1;
              f.dataeom = 1'b1;
            end
          end
          rx_flags = f;
        end
      end
      cec_fr_pkg::KIND_RELEASE: msg_store[0] = '0;
      cec_fr_pkg::KIND_READ: begin
        if (it.read_index <= cec_fr_pkg::BUF_BYTES) r.read_data = msg_store[it.read_index];
      end
      cec_fr_pkg::KIND_ABORT: begin
        if (rx_flags != '0) begin
          r.nack_frame_request = rx_flags.bcast;
          rx_flags = '0;
          r.abort_reported = 1'b1;
          r.reported_error = it.error_code;
        end
      end
      default: ;
    endcase
    r.drive_ack = rx_flags.doack && !monitor;
    r.status_word = msg_store[0];
    r.message_pending = msg_store[0] != 8'd0;
    r.receiving = rx_flags.active;
    return r;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (receiver_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result item with none expected, expected none, actual status %0h",
                 $time, out_status_word);
      end else begin
        next_outcome = receiver_outcomes.pop_front();
        results_seen++;
        if (out_frame_done === 1'b1) frames_finished++;
        check_field("read_data", next_outcome.read_data, out_read_data);
        check_field("drive_ack", next_outcome.drive_ack, out_drive_ack);
        check_field("ack_value", next_outcome.ack_value, out_ack_value);
        check_field("ack_phase", next_outcome.ack_phase, out_ack_phase);
        check_field("frame_done", next_outcome.frame_done, out_frame_done);
        check_field("status_word", next_outcome.status_word, out_status_word);
        check_field("message_pending", next_outcome.message_pending, out_message_pending);
        check_field("nack_frame_request", next_outcome.nack_frame_request,
                    out_nack_frame_request);
        check_field("abort_reported", next_outcome.abort_reported, out_abort_reported);
        check_field("reported_error", next_outcome.reported_error, out_reported_error);
        check_field("receiving", next_outcome.receiving, out_receiving);
      end
    end
  end

  task automatic send_event(logic [2:0] kind, logic bitv, logic [4:0] ridx, logic [7:0] ecode);
    cec_fr_pkg::in_item_t it;
    if (kind == cec_fr_pkg::KIND_READ && ridx >= 1 && ridx <= cec_fr_pkg::BUF_BYTES &&
        !written[ridx]) ridx = '0;
    it.kind = kind;
    it.bit_value = bitv;
    it.read_index = ridx;
    it.error_code = ecode;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_bit_value <= bitv;
    in_read_index <= ridx;
    in_error_code <= ecode;
    do @(posedge clk); while (!in_ready);
    receiver_outcomes.push_back(advance_receiver(it));
    items_sent++;
  endtask

  task automatic send_line_bit(logic b);
    send_event(cec_fr_pkg::KIND_BIT, b, 5'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_event(3'($urandom_range(7)), 1'($urandom), 5'($urandom), 8'($urandom));
  endtask

  // one byte: eight data bits MSB first, EOM, then the ack slot
  task automatic send_byte(logic [7:0] data, logic eom, logic ack_line);
    for (int j = 7; j >= 0; j--) send_line_bit(data[j]);
    send_line_bit(eom);
    send_line_bit(ack_line);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (receiver_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [cec_fr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == cec_fr_pkg::CFG_OWN_MASK) own_mask = data;
    else monitor = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(int nbytes, logic [3:0] dest);
    logic       bcast;
    logic       acked;
    logic [7:0] data;
    int         cut;
    int         k;
    bcast = (dest == cec_fr_pkg::ADDR_BCAST);
    cut = ($urandom_range(9) == 0) ? $urandom_range(nbytes * 10 - 1) : -1;
    k = 0;
    send_event(cec_fr_pkg::KIND_START, 1'($urandom), 5'($urandom), 8'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      data = (i == 0) ? {4'($urandom), dest} : 8'($urandom);
      acked = ($urandom_range(9) != 0);
      for (int j = 9; j >= 0; j--) begin
        if (k == cut) begin
          if ($urandom_range(1))
            send_event(cec_fr_pkg::KIND_ABORT, 1'($urandom), 5'($urandom), 8'($urandom));
          return;
        end
        if ($urandom_range(99) < 2) send_noise();
        if (j >= 2) send_line_bit(data[j - 2]);
        else if (j == 1) send_line_bit(i == nbytes - 1);
        else send_line_bit(bcast ? acked : !acked);
        k++;
      end
      if (!acked) return;
    end
  endtask

  task automatic send_random_sequence();
    int       sel;
    int       nbytes;
    logic [3:0] dest;
    sel = $urandom_range(99);
    if (sel < 75) begin
      nbytes = ($urandom_range(4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      dest = ($urandom_range(3) == 0) ? cec_fr_pkg::ADDR_BCAST : 4'($urandom);
      send_frame(nbytes, dest);
      if ($urandom_range(9) < 6) begin
        send_event(cec_fr_pkg::KIND_READ, 1'($urandom), 5'd0, 8'($urandom));
        repeat ($urandom_range(1, 4))
          send_event(cec_fr_pkg::KIND_READ, 1'($urandom), 5'($urandom_range(20)),
                     8'($urandom));
      end
      if ($urandom_range(3) != 0) send_event(cec_fr_pkg::KIND_RELEASE, 1'($urandom),
                                             5'($urandom), 8'($urandom));
    end else if (sel < 92) begin
      send_noise();
    end else begin
      send_event(cec_fr_pkg::KIND_RELEASE, 1'($urandom), 5'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_idle_events();
    send_event(cec_fr_pkg::KIND_BIT, 1'b1, 5'd0, 8'h00);
    send_event(cec_fr_pkg::KIND_ABORT, 1'b0, 5'd0, 8'hff);
    send_event(KIND_UNKNOWN, 1'b1, 5'd31, 8'hff);
    send_event(cec_fr_pkg::KIND_READ, 1'b0, 5'd17, 8'h00);
  endtask

  task automatic test_broadcast_frame();
    send_event(cec_fr_pkg::KIND_START, 1'b0, 5'd0, 8'h00);
    send_byte(8'hff, 1'b1, 1'b1);
    send_event(cec_fr_pkg::KIND_READ, 1'b0, 5'd1, 8'h00);
    send_event(cec_fr_pkg::KIND_READ, 1'b0, 5'd0, 8'h00);
    send_event(cec_fr_pkg::KIND_RELEASE, 1'b0, 5'd0, 8'h00);
  endtask

  task automatic test_abort_mid_frame();
    send_event(cec_fr_pkg::KIND_START, 1'b0, 5'd0, 8'h00);
    repeat (3) send_line_bit(1'b0);
    send_event(cec_fr_pkg::KIND_ABORT, 1'b0, 5'd0, 8'ha5);
  endtask

  // overrun and saturation of the byte count at 63
  task automatic test_position_saturation();
    send_event(cec_fr_pkg::KIND_RELEASE, 1'b0, 5'd0, 8'h00);
    send_event(cec_fr_pkg::KIND_START, 1'b0, 5'd0, 8'h00);
    for (int i = 0; i < 66; i++) send_byte(i == 0 ? 8'h03 : 8'($urandom), i == 65, 1'b0);
    send_event(cec_fr_pkg::KIND_READ, 1'b0, 5'd0, 8'h00);
    send_event(cec_fr_pkg::KIND_RELEASE, 1'b0, 5'd0, 8'h00);
  endtask

  task automatic test_random_traffic(int idle, int stall, logic [15:0] mask, logic mon, int n);
    int stop_at;
    wait_idle();
    cfg_write(cec_fr_pkg::CFG_OWN_MASK, mask);
    cfg_write(cec_fr_pkg::CFG_MONITOR, {15'($urandom), mon});
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_random_sequence();
  endtask

  initial begin
    for (int i = 0; i <= cec_fr_pkg::BUF_BYTES; i++) msg_store[i] = '0;
    shift_reg = '0;
    byte_pos = '0;
    rx_flags = '0;
    own_mask = '0;
    monitor = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_events();
    test_broadcast_frame();
    test_abort_mid_frame();
    test_random_traffic(0, 0, 16'hffff, 1'b0, 120);
    test_random_traffic(46, 0, 16'h0000, 1'b0, 120);
    test_random_traffic(0, 46, 16'($urandom), 1'b1, 120);
    test_random_traffic(7, 7, 16'h8000, 1'b0, 120);
    test_random_traffic(0, 0, 16'($urandom), 1'b0, 0);
    test_position_saturation();
    test_random_traffic(46, 0, 16'hffff, 1'b1, 100);
    test_random_traffic(0, 46, 16'($urandom), 1'($urandom), 100);
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d events, checked %0d results, %0d frames completed, %0d mismatches",
             items_sent, results_seen, frames_finished, mismatches);
    if (mismatches == 0 && receiver_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cec_fr_pkg.sv
rtl/core/cec_fr_in_stage.sv
rtl/core/cec_fr_engine.sv
rtl/core/cec_frame_receiver.sv
dv/testbench.sv
